>>> hw/rtl/phcal_pkg.sv
// ----------------------------------------------------------------------------
// phcal_pkg
// Shared types and constants of the two-point pH probe calibration block:
// operation and status codes, buffer windows, reset levels, divider bundles.
// ----------------------------------------------------------------------------
package phcal_pkg;

    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned PH_W    = 14;
    localparam int unsigned DIVD_W  = 26;
    localparam int unsigned QUO_W   = 14;

    localparam logic [VOLT_W-1:0]  NEUTRAL_LO    = 16'd2480;
    localparam logic [VOLT_W-1:0]  NEUTRAL_HI    = 16'd2640;
    localparam logic [VOLT_W-1:0]  ACID_LO       = 16'd2880;
    localparam logic [VOLT_W-1:0]  ACID_HI       = 16'd3040;
    localparam logic [LEVEL_W-1:0] NEUTRAL_RESET = 12'd2560;
    localparam logic [LEVEL_W-1:0] ACID_RESET    = 12'd2960;
    localparam logic [PH_W-1:0]    PH_MAX        = 14'h1FFF;
    localparam logic [PH_W-1:0]    PH_MIN        = 14'h2000;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_IDLE    = 3'd1,
        OP_ENTER   = 3'd2,
        OP_CAPTURE = 3'd3,
        OP_EXIT    = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_CMD_ERR = 4'd1,
        ST_ENTERED = 4'd2,
        ST_NEUTRAL = 4'd3,
        ST_ACID    = 4'd4,
        ST_BUF_ERR = 4'd5,
        ST_SUCCESS = 4'd6,
        ST_FAILED  = 4'd7,
        ST_IGNORED = 4'd8
    } status_t;

    typedef struct packed {
        logic               start;
        logic [DIVD_W-1:0]  dividend;
        logic [LEVEL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/phcal_div.sv
// ----------------------------------------------------------------------------
// phcal_div
// Serial restoring divider: one quotient bit per cycle, MSB first. The caller
// guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module phcal_div
    import phcal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned DSH_W = LEVEL_W + QUO_W - 1;

    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ge;

    assign ge = rem_reg >= {1'b0, dsh_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dsh_next  = {req.divisor, {(QUO_W-1){1'b0}}};
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - {1'b0, dsh_reg};
            end
            quo_next = {quo_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> hw/rtl/ph_probe_two_point_calibration.sv
// ----------------------------------------------------------------------------
// ph_probe_two_point_calibration
// Two-point pH probe calibration and conversion with a serial divider.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block works on one beat at a time:
// calibration operations pass through S_EXEC to S_DONE; a pH read goes
// through S_EXEC, S_PREP, S_CHECK, S_DIV and S_FIN to S_DONE (skipping S_DIV
// and S_FIN when the result is zero or saturates), S_DIV being the 14-step
// restoring divider. A finished result sits in the output register, and the
// next input beat is accepted while it waits to be taken.
module ph_probe_two_point_calibration
    import phcal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] voltage
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [13:0] ph_value, [14] save_pulse,
                                   // [26:15] neutral_out, [38:27] acid_out, [39] zero
    output logic [3:0]  m_tuser    // [3:0] status
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VOLT_W-1:0]  volt_reg, volt_next;
    logic [LEVEL_W-1:0] neutral_reg, neutral_next;
    logic [LEVEL_W-1:0] acid_reg, acid_next;
    logic               in_cal_reg, in_cal_next;
    logic               cap_done_reg, cap_done_next;
    logic signed [12:0] d_reg, d_next;
    logic signed [17:0] e_reg, e_next;
    logic signed [18:0] m_reg, m_next;
    logic [LEVEL_W-1:0] dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic [PH_W-1:0]    ph_reg, ph_next;
    status_t            status_reg, status_next;
    logic               save_reg, save_next;
    logic               ovalid_reg, ovalid_next;
    logic [39:0]        odata_reg, odata_next;
    logic [3:0]         ouser_reg, ouser_next;

    logic               in_neutral;
    logic               in_acid;
    logic [17:0]        m_mag;
    logic [QUO_W-1:0]   quo;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign in_neutral = (volt_reg > NEUTRAL_LO) && (volt_reg < NEUTRAL_HI);
    assign in_acid    = (volt_reg > ACID_LO) && (volt_reg < ACID_HI);
    assign m_mag      = m_reg[18] ? 18'(-m_reg) : m_reg[17:0];
    assign quo        = div_rsp.quotient;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        volt_next     = volt_reg;
        neutral_next  = neutral_reg;
        acid_next     = acid_reg;
        in_cal_next   = in_cal_reg;
        cap_done_next = cap_done_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        m_next        = m_reg;
        dmag_next     = dmag_reg;
        neg_next      = neg_reg;
        ph_next       = ph_reg;
        status_next   = status_reg;
        save_next     = save_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        ouser_next    = ouser_reg;
        div_req       = '{start: 1'b0, dividend: {m_mag, 8'd0}, divisor: dmag_reg};

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    volt_next  = s_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ph_next     = '0;
                save_next   = 1'b0;
                status_next = ST_IGNORED;
                state_next  = S_DONE;
                unique case (op_reg)
                    OP_READ:
                    begin
                        status_next = ST_OK;
                        d_next      = $signed({1'b0, neutral_reg}) - $signed({1'b0, acid_reg});
                        e_next      = $signed({2'b00, volt_reg})
                                    - $signed({6'd0, neutral_reg});
                        state_next  = S_PREP;
                    end
                    OP_IDLE:
                    begin
                        status_next = in_cal_reg ? ST_CMD_ERR : ST_IGNORED;
                    end
                    OP_ENTER:
                    begin
                        in_cal_next   = 1'b1;
                        cap_done_next = 1'b0;
                        status_next   = ST_ENTERED;
                    end
                    OP_CAPTURE:
                    begin
                        if (in_cal_reg)
                        begin
                            priority if (in_neutral)
                            begin
                                neutral_next  = volt_reg[LEVEL_W-1:0];
                                cap_done_next = 1'b1;
                                status_next   = ST_NEUTRAL;
                            end
                            else if (in_acid)
                            begin
                                acid_next     = volt_reg[LEVEL_W-1:0];
                                cap_done_next = 1'b1;
                                status_next   = ST_ACID;
                            end
                            else
                            begin
                                cap_done_next = 1'b0;
                                status_next   = ST_BUF_ERR;
                            end
                        end
                    end
                    OP_EXIT:
                    begin
                        if (in_cal_reg)
                        begin
                            if (cap_done_reg)
                            begin
                                save_next   = in_neutral || in_acid;
                                status_next = ST_SUCCESS;
                            end
                            else
                            begin
                                status_next = ST_FAILED;
                            end
                            cap_done_next = 1'b0;
                            in_cal_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_IGNORED;
                    end
                endcase
            end
            S_PREP:
            begin
                m_next = ($signed({{6{d_reg[12]}}, d_reg}) <<< 3)
                       - $signed({{6{d_reg[12]}}, d_reg})
                       + ($signed({e_reg[17], e_reg}) <<< 1)
                       + $signed({e_reg[17], e_reg});
                dmag_next  = d_reg[12] ? 12'(-d_reg) : d_reg[11:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                neg_next = m_reg[18] ^ d_reg[12];
                priority if (m_reg == '0)
                begin
                    ph_next    = '0;
                    state_next = S_DONE;
                end
                else if (m_mag >= {dmag_reg, 6'd0})
                begin
                    ph_next    = (m_reg[18] ^ d_reg[12]) ? PH_MIN : PH_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (neg_reg)
                begin
                    ph_next = quo[PH_W-1] ? PH_MIN : 14'(-quo);
                end
                else
                begin
                    ph_next = quo[PH_W-1] ? PH_MAX : quo;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {1'b0, acid_reg, neutral_reg, save_reg, ph_reg};
                    ouser_next  = status_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            neutral_reg  <= NEUTRAL_RESET;
            acid_reg     <= ACID_RESET;
            in_cal_reg   <= 1'b0;
            cap_done_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            neutral_reg  <= neutral_next;
            acid_reg     <= acid_next;
            in_cal_reg   <= in_cal_next;
            cap_done_reg <= cap_done_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        volt_reg   <= volt_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        ph_reg     <= ph_next;
        status_reg <= status_next;
        save_reg   <= save_next;
        odata_reg  <= odata_next;
        ouser_reg  <= ouser_next;
    end

    phcal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

endmodule

>>> hw/rtl/phcal_check.sv
// ----------------------------------------------------------------------------
// phcal_check
// Port-level checks of the pH calibration block, bound to the top level.
// ----------------------------------------------------------------------------
module phcal_check
    import phcal_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in flight");

    a_ph_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[13:0] == 14'd0))
        else $error("nonzero pH on a calibration result");

    a_save_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> (m_tuser == ST_SUCCESS))
        else $error("save pulse without successful exit");

endmodule

bind ph_probe_two_point_calibration phcal_check u_phcal_check (.*);
